// File: sv/madsr_pkg.sv
`timescale 1ns / 1ps

package madsr_pkg;

	// request codes; code 3 is a no-op
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// phase_flags bits
	localparam int F_START_BIT   = 4;
	localparam int F_RELEASE_BIT = 3;
	localparam int F_ECHO_BIT    = 2;

	localparam logic [4:0] FLAGS_IDLE  = 5'h00;
	localparam logic [4:0] FLAGS_START = 5'h10;

	localparam logic [1:0] PH_ATTACK  = 2'd3;
	localparam logic [1:0] PH_DECAY   = 2'd2;
	localparam logic [1:0] PH_SUSTAIN = 2'd1;

	localparam logic [7:0] LEVEL_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] channel;
		logic [7:0] attack_step;
		logic [7:0] decay_factor;
		logic [7:0] sustain_level;
		logic [7:0] release_factor;
		logic [7:0] echo_level;
	} req_item_t;

	typedef struct packed {
		logic [3:0] out_channel;
		logic       active;
		logic [7:0] envelope_level;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0] release_factor;
		logic [7:0] sustain_level;
		logic [7:0] decay_factor;
		logic [7:0] attack_step;
	} note_params_t;

	typedef struct packed {
		logic [4:0]   phase_flags;
		logic [7:0]   env_level;
		logic [7:0]   echo_count;
		note_params_t params;
	} chan_state_t;

endpackage

// File: sv/multichannel_adsr_envelope_core.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload              Width
// req      req_valid/req_ready  madsr_pkg::req_item_t  46
// rsp      rsp_valid/rsp_ready  madsr_pkg::rsp_item_t  13
//
// One transaction per cycle sustained while results are taken; each request's result
// passes through the stage-1 registers (state memory read at acceptance), then the result register.
// Channel state lives in a one-port-write, one-port-read memory with a
// registered read; a one-entry forward register covers back-to-back
// transactions on the same channel.
// Reset clears per-channel valid bits at once; no clearing pass is needed.
// A stalled result holds the update stage, which then blocks req_ready.

module multichannel_adsr_envelope_core #(
	parameter int NUM_CHANNELS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  madsr_pkg::req_item_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output madsr_pkg::rsp_item_t rsp
);
	import madsr_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	chan_state_t mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;

	logic             req_accept;
	logic [IDX_W-1:0] rd_idx;
	logic             rd_in_range;

	logic             valid_s1;
	req_item_t        item_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             in_range_s1;
	chan_state_t      rd_data_s1;
	logic             rd_vld_s1;

	logic             fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	chan_state_t      fwd_data_q;

	chan_state_t      cur_s1;
	chan_state_t      nxt_s1;
	logic             adv_s1;
	logic             wr_en;

	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	assign rd_idx      = IDX_W'(req.channel);
	assign rd_in_range = {3'b000, req.channel} < 7'(NUM_CHANNELS);

	assign adv_s1     = !rsp_valid_q || rsp_ready;
	assign req_ready  = !valid_s1 || adv_s1;
	assign req_accept = req_valid && req_ready;
	assign wr_en      = valid_s1 && adv_s1 && in_range_s1;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			item_s1     <= req;
			idx_s1      <= rd_idx;
			in_range_s1 <= rd_in_range;
			rd_vld_s1   <= rd_in_range && vld_q[rd_idx];
		end
	end

	// state memory: read at acceptance, write back when stage 1 advances
	always_ff @(posedge clk) begin
		if (req_accept)
			rd_data_s1 <= mem[rd_idx];
		if (wr_en)
			mem[idx_s1] <= nxt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			vld_q[idx_s1] <= 1'b1;
			fwd_valid_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= nxt_s1;
		end
	end

	// the last write may have landed after this transaction's read
	always_comb begin
		if (fwd_valid_q && fwd_idx_q == idx_s1)
			cur_s1 = fwd_data_q;
		else if (rd_vld_s1)
			cur_s1 = rd_data_s1;
		else
			cur_s1 = '0;
	end

	madsr_update u_update (
		.item (item_s1),
		.cur  (cur_s1),
		.nxt  (nxt_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			rsp_q.out_channel    <= item_s1.channel;
			rsp_q.active         <= in_range_s1 && (nxt_s1.phase_flags != FLAGS_IDLE);
			rsp_q.envelope_level <= in_range_s1 ? nxt_s1.env_level : 8'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ({3'b000, rsp.out_channel} >= 7'(NUM_CHANNELS))
		|-> (!rsp.active && rsp.envelope_level == 8'd0))
		else $error("out-of-range channel reported activity");

	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 && in_range_s1 && item_s1.req_type == REQ_START
		|=> rsp_valid && rsp.active)
		else $error("note start did not report an active channel");

	a_idle_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 && cur_s1.phase_flags == FLAGS_IDLE
		&& (item_s1.req_type == REQ_TICK || item_s1.req_type == REQ_STOP)
		|=> rsp_valid && !rsp.active)
		else $error("idle channel woke up without a note start");

	a_no_write_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !wr_en && !req_ready)
		else $error("state written or request taken while result stalled");
`endif

endmodule

// File: sv/madsr_update.sv
`timescale 1ns / 1ps

module madsr_update (
	input  madsr_pkg::req_item_t   item,
	input  madsr_pkg::chan_state_t cur,
	output madsr_pkg::chan_state_t nxt
);
	import madsr_pkg::*;

	logic [7:0]  factor;
	logic [15:0] product;
	logic [7:0]  scaled;
	logic [8:0]  attack_sum;
	logic [7:0]  echo_dec;

	assign factor     = cur.phase_flags[F_RELEASE_BIT] ? cur.params.release_factor
	                                                   : cur.params.decay_factor;
	assign product    = 16'(cur.env_level) * 16'(factor);
	assign scaled     = product[15:8];
	assign attack_sum = 9'(cur.env_level) + 9'(cur.params.attack_step);
	assign echo_dec   = cur.echo_count - 8'd1;

	always_comb begin
		nxt = cur;
		unique case (item.req_type)
			REQ_TICK: begin
				if (cur.phase_flags == FLAGS_IDLE) begin
					nxt = cur;
				end else if (cur.phase_flags[F_START_BIT]) begin
					if (cur.phase_flags[F_RELEASE_BIT]) begin
						// stop arrived before the note began: cancel
						nxt.phase_flags = FLAGS_IDLE;
					end else begin
						nxt.phase_flags = {3'b000, PH_ATTACK};
						nxt.env_level   = cur.params.attack_step;
					end
				end else if (cur.phase_flags[F_ECHO_BIT]) begin
					nxt.echo_count = echo_dec;
					if (echo_dec == 8'd0)
						nxt.phase_flags = FLAGS_IDLE;
				end else if (cur.phase_flags[F_RELEASE_BIT]) begin
					nxt.env_level = scaled;
					if (scaled <= cur.echo_count) begin
						if (cur.echo_count == 8'd0)
							nxt.phase_flags = FLAGS_IDLE;
						else
							nxt.phase_flags[F_ECHO_BIT] = 1'b1;
					end
				end else begin
					unique case (cur.phase_flags[1:0])
						PH_DECAY: begin
							nxt.env_level = scaled;
							if (scaled <= cur.params.sustain_level) begin
								if (cur.params.sustain_level == 8'd0) begin
									if (cur.echo_count == 8'd0)
										nxt.phase_flags = FLAGS_IDLE;
									else
										nxt.phase_flags[F_ECHO_BIT] = 1'b1;
								end else begin
									nxt.env_level        = cur.params.sustain_level;
									nxt.phase_flags[1:0] = PH_SUSTAIN;
								end
							end
						end
						PH_ATTACK: begin
							if (attack_sum[8]) begin
								nxt.env_level        = LEVEL_MAX;
								nxt.phase_flags[1:0] = PH_DECAY;
							end else begin
								nxt.env_level = attack_sum[7:0];
							end
						end
						default: nxt = cur;
					endcase
				end
			end
			REQ_START: begin
				nxt.params.attack_step    = item.attack_step;
				nxt.params.decay_factor   = item.decay_factor;
				nxt.params.sustain_level  = item.sustain_level;
				nxt.params.release_factor = item.release_factor;
				nxt.echo_count            = item.echo_level;
				nxt.phase_flags           = FLAGS_START;
			end
			REQ_STOP: begin
				if (cur.phase_flags != FLAGS_IDLE)
					nxt.phase_flags[F_RELEASE_BIT] = 1'b1;
			end
			default: nxt = cur;
		endcase
	end

endmodule

// File: tb/tb_multichannel_adsr_envelope_core.sv
`timescale 1ns / 1ps

module tb_multichannel_adsr_envelope_core;
	import madsr_pkg::*;

	localparam int NUM_CH = 16;
	localparam int ITEMS_PER_PHASE = 380;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] REQ_NOP = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_item_t  req;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_item_t  rsp;

	multichannel_adsr_envelope_core #(
		.NUM_CHANNELS(NUM_CH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// per-channel envelope state kept by the predictor
	logic [4:0]   ch_flags [NUM_CH];
	logic [7:0]   ch_level [NUM_CH];
	logic [7:0]   ch_echo  [NUM_CH];
	note_params_t ch_prm   [NUM_CH];

	rsp_item_t env_results_q [$];
	rsp_item_t env_want;

	int unsigned src_idle_pct  = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned cycle_cnt     = 0;
	int unsigned n_mismatch    = 0;
	int unsigned n_sent        = 0;
	int unsigned n_checked     = 0;
	int unsigned n_ticks       = 0;
	int unsigned n_starts      = 0;
	int unsigned n_stops       = 0;
	int unsigned n_nops        = 0;
	int unsigned n_cancel      = 0;
	int unsigned n_sustain     = 0;
	int unsigned n_echo_done   = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, env_results_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		n_mismatch++;
		$display("[%0t] result %0d: %s got %0d, want %0d", $realtime, n_checked, what, got,
			want);
	endtask

	// level fell to the echo threshold: go idle, or enter the echo tail
	function automatic void fade_out(int unsigned c);
		if (ch_echo[c] == 8'd0)
			ch_flags[c] = FLAGS_IDLE;
		else
			ch_flags[c][F_ECHO_BIT] = 1'b1;
	endfunction

	function automatic rsp_item_t predict_envelope(req_item_t item);
		rsp_item_t   r;
		int unsigned c;
		logic [4:0]  f;
		logic [15:0] prod;
		logic [8:0]  sum;
		c = 32'(item.channel);
		r.out_channel = item.channel;
		r.active = 1'b0;
		r.envelope_level = 8'd0;
		if (c >= NUM_CH)
			return r;
		f = ch_flags[c];
		case (item.req_type)
			REQ_TICK: begin
				if (f == FLAGS_IDLE) begin
				end else if (f[F_START_BIT]) begin
					if (f[F_RELEASE_BIT]) begin
						ch_flags[c] = FLAGS_IDLE;
						n_cancel++;
					end else begin
						ch_flags[c] = {3'b000, PH_ATTACK};
						ch_level[c] = ch_prm[c].attack_step;
					end
				end else if (f[F_ECHO_BIT]) begin
					ch_echo[c] = ch_echo[c] - 8'd1;
					if (ch_echo[c] == 8'd0) begin
						ch_flags[c] = FLAGS_IDLE;
						n_echo_done++;
					end
				end else if (f[F_RELEASE_BIT]) begin
					prod = 16'(ch_level[c]) * 16'(ch_prm[c].release_factor);
					ch_level[c] = prod[15:8];
					if (prod[15:8] <= ch_echo[c])
						fade_out(c);
				end else begin
					case (f[1:0])
						PH_DECAY: begin
							prod = 16'(ch_level[c]) * 16'(ch_prm[c].decay_factor);
							ch_level[c] = prod[15:8];
							if (prod[15:8] <= ch_prm[c].sustain_level) begin
								if (ch_prm[c].sustain_level == 8'd0) begin
									fade_out(c);
								end else begin
									ch_level[c] = ch_prm[c].sustain_level;
									ch_flags[c][1:0] = PH_SUSTAIN;
									n_sustain++;
								end
							end
						end
						PH_ATTACK: begin
							sum = 9'(ch_level[c]) + 9'(ch_prm[c].attack_step);
							if (sum[8]) begin
								ch_level[c] = LEVEL_MAX;
								ch_flags[c][1:0] = PH_DECAY;
							end else begin
								ch_level[c] = sum[7:0];
							end
						end
						default: ;
					endcase
				end
			end
			REQ_START: begin
				ch_prm[c].attack_step    = item.attack_step;
				ch_prm[c].decay_factor   = item.decay_factor;
				ch_prm[c].sustain_level  = item.sustain_level;
				ch_prm[c].release_factor = item.release_factor;
				ch_echo[c]  = item.echo_level;
				ch_flags[c] = FLAGS_START;
			end
			REQ_STOP: begin
				if (ch_flags[c] != FLAGS_IDLE)
					ch_flags[c][F_RELEASE_BIT] = 1'b1;
			end
			default: ;
		endcase
		r.active = (ch_flags[c] != FLAGS_IDLE);
		r.envelope_level = ch_level[c];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (env_results_q.size() == 0) begin
				report_mismatch("unexpected result, out_channel", int'(rsp.out_channel), -1);
			end else begin
				env_want = env_results_q.pop_front();
				if (rsp.out_channel !== env_want.out_channel)
					report_mismatch("out_channel", int'(rsp.out_channel),
						int'(env_want.out_channel));
				if (rsp.active !== env_want.active)
					report_mismatch("active", int'(rsp.active), int'(env_want.active));
				if (rsp.envelope_level !== env_want.envelope_level)
					report_mismatch("envelope_level", int'(rsp.envelope_level),
						int'(env_want.envelope_level));
				n_checked++;
			end
		end
	end

	function automatic req_item_t make_req(logic [1:0] kind, logic [3:0] ch, logic [7:0] atk,
		logic [7:0] dcy, logic [7:0] sus, logic [7:0] rel, logic [7:0] echo);
		req_item_t r;
		r.req_type       = kind;
		r.channel        = ch;
		r.attack_step    = atk;
		r.decay_factor   = dcy;
		r.sustain_level  = sus;
		r.release_factor = rel;
		r.echo_level     = echo;
		return r;
	endfunction

	// entered and left just after a falling edge, with req_valid low
	task automatic send_req(input req_item_t item);
		while ($urandom_range(99) < src_idle_pct)
			@(negedge clk);
		req = item;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		env_results_q.push_back(predict_envelope(item));
		n_sent++;
		case (item.req_type)
			REQ_TICK:  n_ticks++;
			REQ_START: n_starts++;
			REQ_STOP:  n_stops++;
			default:   n_nops++;
		endcase
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (env_results_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic req_item_t random_req(logic [3:0] prev_ch);
		req_item_t   r;
		int unsigned pick;
		r = make_req(REQ_TICK, 4'd0, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		pick = $urandom_range(99);
		if (pick < 9)
			r.req_type = REQ_START;
		else if (pick < 16)
			r.req_type = REQ_STOP;
		else if (pick < 19)
			r.req_type = REQ_NOP;
		pick = $urandom_range(99);
		// favor a few channels, often back to back, so notes run through all phases
		if (pick < 25)
			r.channel = prev_ch;
		else if (pick < 75)
			r.channel = 4'($urandom_range(3));
		else
			r.channel = 4'($urandom_range(15));
		if (r.req_type == REQ_START && $urandom_range(1) == 0) begin
			r.attack_step    = 8'($urandom_range(32, 255));
			r.decay_factor   = 8'($urandom_range(96, 240));
			r.sustain_level  = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(160));
			r.release_factor = 8'($urandom_range(64, 230));
			r.echo_level     = 8'($urandom_range(10));
		end
		return r;
	endfunction

	task automatic run_random(input int unsigned n);
		req_item_t item;
		logic [3:0] prev_ch;
		prev_ch = 4'd0;
		repeat (n) begin
			item = random_req(prev_ch);
			prev_ch = item.channel;
			send_req(item);
		end
		// hold off until every result is back
		wait_drained();
	endtask

	task automatic test_directed();
		send_req(make_req(REQ_TICK, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(REQ_STOP, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_req(make_req(REQ_NOP, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// full attack step saturates, then decay into sustain and release
		send_req(make_req(REQ_START, 4'd15, 8'hFF, 8'h80, 8'h40, 8'hC7, 8'h00));
		repeat (5) send_req(make_req(REQ_TICK, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(REQ_STOP, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(REQ_TICK, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// zero attack step stays in attack
		send_req(make_req(REQ_START, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		repeat (2) send_req(make_req(REQ_TICK, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(REQ_STOP, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(REQ_TICK, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// stop while the start is still pending cancels the note
		send_req(make_req(REQ_START, 4'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_req(make_req(REQ_STOP, 4'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(REQ_TICK, 4'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// zero sustain decays into the echo tail, which counts down to idle
		send_req(make_req(REQ_START, 4'd3, 8'h80, 8'h00, 8'h00, 8'hFF, 8'h02));
		repeat (5) send_req(make_req(REQ_TICK, 4'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// restart a busy channel; release with zero factor enters the echo tail
		send_req(make_req(REQ_START, 4'd15, 8'h10, 8'hFF, 8'hFF, 8'h00, 8'h01));
		send_req(make_req(REQ_TICK, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(REQ_STOP, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		repeat (2) send_req(make_req(REQ_TICK, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		wait_drained();
	endtask

	task automatic test_streaming();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		run_random(ITEMS_PER_PHASE);
	endtask

	task automatic test_sender_gaps();
		src_idle_pct = 46;
		sink_stall_pct = 0;
		run_random(ITEMS_PER_PHASE);
	endtask

	task automatic test_receiver_stalls();
		src_idle_pct = 0;
		sink_stall_pct = 46;
		run_random(ITEMS_PER_PHASE);
	endtask

	task automatic test_both_idle();
		src_idle_pct = 9;
		sink_stall_pct = 9;
		run_random(ITEMS_PER_PHASE);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			ch_flags[i] = FLAGS_IDLE;
			ch_level[i] = 8'd0;
			ch_echo[i]  = 8'd0;
			ch_prm[i]   = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		repeat (10) @(negedge clk);

		$display("covered %0d transactions: %0d ticks, %0d starts, %0d stops, %0d no-ops",
			n_sent, n_ticks, n_starts, n_stops, n_nops);
		$display("compared %0d results; %0d cancels, %0d sustain entries, %0d echo tails done",
			n_checked, n_cancel, n_sustain, n_echo_done);
		if (n_mismatch == 0 && env_results_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", n_mismatch, env_results_q.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/madsr_pkg.sv
sv/madsr_update.sv
sv/multichannel_adsr_envelope_core.sv
tb/tb_multichannel_adsr_envelope_core.sv
